[rtl/iir4_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iir4_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int CH_W           = 3;
	localparam int CNT_W          = 4;
	localparam int COEF_W         = 32;
	localparam int COEF_FRAC      = COEF_W - 4;
	localparam int STATE_W        = 48;
	localparam int MAX_CH_DEFAULT = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = COEF_W;
	localparam int TAPS           = 4;

	localparam int PROD_W   = COEF_W + SAMPLE_W;
	localparam int SAT_IN_W = COEF_W + STATE_W + 2;
	localparam int SPLIT_W  = STATE_W / 2;
	localparam int HI_W     = STATE_W - SPLIT_W;
	localparam int LO_PW    = COEF_W + SPLIT_W + 1;
	localparam int HI_PW    = COEF_W + HI_W;
	localparam int FULL_W   = COEF_W + STATE_W;
	localparam int Q_W      = STATE_W - COEF_FRAC;

	localparam logic [CNT_W-1:0] CH_COUNT_RESET = CNT_W'(2);
	localparam logic [Q_W-1:0] SAMPLE_POS_LIMIT = Q_W'(32767);
	localparam logic [Q_W-1:0] SAMPLE_NEG_LIMIT = Q_W'(32768);
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	localparam logic signed [SAT_IN_W-1:0] ST_MAX_W =
		$signed({{(SAT_IN_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}});
	localparam logic signed [SAT_IN_W-1:0] ST_MIN_W =
		$signed({{(SAT_IN_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}});

	typedef logic signed [STATE_W-1:0] state_t;
	typedef logic signed [SAT_IN_W-1:0] wide_t;
	typedef logic [TAPS-1:0][STATE_W-1:0] row_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT = 3'd0,
		REG_HIGHPASS      = 3'd1,
		REG_GAIN          = 3'd2,
		REG_FB_ONE        = 3'd3,
		REG_FB_TWO        = 3'd4,
		REG_FB_THREE      = 3'd5,
		REG_FB_FOUR       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]             channel_count;
		logic                         highpass;
		logic [COEF_W-1:0]            gain;
		logic [TAPS-1:0][COEF_W-1:0]  feedback;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_Y,
		ST_LO,
		ST_HI,
		ST_SUM,
		ST_UPD
	} state_e_t;

	typedef struct packed {
		logic load;
		logic calc_y;
		logic mul_lo;
		logic mul_hi;
		logic sum;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
	} status_t;

	// clamp to the signed state range
	function automatic state_t sat_state(input wide_t v);
		state_t r;
		if (v > ST_MAX_W) begin
			r = ST_MAX_W[STATE_W-1:0];
		end else if (v < ST_MIN_W) begin
			r = ST_MIN_W[STATE_W-1:0];
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

	function automatic state_t sat_add(input state_t a, input state_t b);
		return sat_state(SAT_IN_W'(a) + SAT_IN_W'(b));
	endfunction

endpackage

`default_nettype wire

[rtl/iir4_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module iir4_cfg
	import iir4_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{channel_count: CH_COUNT_RESET, highpass: 1'b0, gain: '0,
				feedback: '0};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[CNT_W-1:0];
				REG_HIGHPASS:      cfg_q.highpass      <= cfg_data[0];
				REG_GAIN:          cfg_q.gain          <= cfg_data[COEF_W-1:0];
				REG_FB_ONE:        cfg_q.feedback[0]   <= cfg_data[COEF_W-1:0];
				REG_FB_TWO:        cfg_q.feedback[1]   <= cfg_data[COEF_W-1:0];
				REG_FB_THREE:      cfg_q.feedback[2]   <= cfg_data[COEF_W-1:0];
				REG_FB_FOUR:       cfg_q.feedback[3]   <= cfg_data[COEF_W-1:0];
				// drop writes to unmapped indexes
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/iir4_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module iir4_ctrl
	import iir4_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_e_t state_q;
	state_e_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_Y;
			ST_Y:    state_d = ST_LO;
			ST_LO:   state_d = ST_HI;
			ST_HI:   state_d = ST_SUM;
			ST_SUM:  state_d = ST_UPD;
			// hold until the output register can take the result
			ST_UPD:  if (status.slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_Y:    cmd.calc_y = 1'b1;
			ST_LO:   cmd.mul_lo = 1'b1;
			ST_HI:   cmd.mul_hi = 1'b1;
			ST_SUM:  cmd.sum    = 1'b1;
			ST_UPD:  cmd.commit = status.slot_free;
			default: cmd        = '0;
		endcase
	end

`ifndef ASSERT_OFF
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_Y)
		else $error("load did not start the item");
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");
	a_upd_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && !status.slot_free |=> state_q == ST_UPD)
		else $error("left update while output slot busy");
	a_sum_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |=> state_q == ST_UPD)
		else $error("sum step not followed by update");
`endif

endmodule

`default_nettype wire

[rtl/iir4_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module iir4_dp
	import iir4_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CH_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cfg_t                       cfg,
	input  wire cmd_t                       cmd,
	output status_t                         status,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic [CH_W-1:0]            channel,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      sample_out,
	output logic [CH_W-1:0]                 out_channel
);

	localparam int CH_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	row_t delay_mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] row_vld_q;

	logic [CH_IW-1:0] in_idx;
	logic             in_active;

	logic [CH_IW-1:0]          idx_q;
	logic [CH_W-1:0]           ch_q;
	logic                      active_q;
	logic                      rvld_q;
	row_t                      row_q;
	logic signed [PROD_W-1:0]  p_q;
	state_t                    y_q;
	state_t                    ff0_q;
	state_t                    ff1_q;
	state_t                    ff2_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic signed [LO_PW-1:0]   lo_q [TAPS];
	logic signed [HI_PW-1:0]   hi_q [TAPS];
	state_t                    fbv_q [TAPS];

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic [CH_W-1:0]            out_channel_q;

	state_t                    d_old [TAPS];
	state_t                    ff0_d;
	state_t                    ff1_d;
	state_t                    ff2_d;
	state_t                    y_d;
	logic signed [FULL_W-1:0]  full_d [TAPS];
	logic signed [FULL_W-1:0]  shr_d [TAPS];
	row_t                      row_new;
	logic                      y_neg;
	logic [STATE_W-1:0]        y_mag;
	logic [Q_W-1:0]            y_q_int;
	logic signed [SAMPLE_W-1:0] res_d;
	logic signed [PROD_W+2:0]  p4;
	logic signed [PROD_W+2:0]  p2;

	assign in_idx    = CH_IW'(channel);
	assign in_active = (CNT_W'(channel) < cfg.channel_count) && (32'(channel) < MAX_CHANNELS);

	assign status.slot_free = !out_valid_q || out_ready;

	// delay rows: one read at load, one write at commit for an active channel
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q <= delay_mem[in_idx];
		end
		if (cmd.commit && active_q) begin
			delay_mem[idx_q] <= row_new;
		end
	end

	// rows never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (cmd.commit && active_q) begin
			row_vld_q[idx_q] <= 1'b1;
		end
	end

	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			d_old[k] = rvld_q ? $signed(row_q[k]) : '0;
		end
	end

	// feed-forward terms and accumulator
	always_comb begin
		p4    = (PROD_W+3)'(p_q) <<< 2;
		p2    = (PROD_W+3)'(p_q) <<< 1;
		ff0_d = sat_state(SAT_IN_W'(p_q));
		ff1_d = sat_state(cfg.highpass ? -SAT_IN_W'(p4) : SAT_IN_W'(p4));
		ff2_d = sat_state(SAT_IN_W'(p4) + SAT_IN_W'(p2));
		y_d   = sat_add(ff0_d, d_old[0]);
	end

	// output sample: truncate toward zero, then clip
	always_comb begin
		y_neg   = y_q[STATE_W-1];
		y_mag   = y_neg ? STATE_W'(-y_q) : STATE_W'(y_q);
		y_q_int = Q_W'(y_mag >> COEF_FRAC);
		if (!y_neg) begin
			res_d = (y_q_int > SAMPLE_POS_LIMIT) ? SAMPLE_MAX : $signed(y_q_int[SAMPLE_W-1:0]);
		end else begin
			res_d = (y_q_int > SAMPLE_NEG_LIMIT) ? SAMPLE_MIN :
				-$signed(y_q_int[SAMPLE_W-1:0]);
		end
	end

	// feedback product from its two partial products, floor shift
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			full_d[k] = (FULL_W'(hi_q[k]) <<< SPLIT_W) + FULL_W'(lo_q[k]);
			shr_d[k]  = full_d[k] >>> COEF_FRAC;
		end
	end

	always_comb begin
		row_new[0] = sat_add(sat_add(ff1_q, fbv_q[0]), d_old[1]);
		row_new[1] = sat_add(sat_add(ff2_q, fbv_q[1]), d_old[2]);
		row_new[2] = sat_add(sat_add(ff1_q, fbv_q[2]), d_old[3]);
		row_new[3] = sat_add(ff0_q, fbv_q[3]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q      <= PROD_W'($signed(cfg.gain)) * PROD_W'(sample_in);
			idx_q    <= in_idx;
			ch_q     <= channel;
			active_q <= in_active;
			rvld_q   <= row_vld_q[in_idx];
		end
		if (cmd.calc_y) begin
			y_q   <= y_d;
			ff0_q <= ff0_d;
			ff1_q <= ff1_d;
			ff2_q <= ff2_d;
		end
		if (cmd.mul_lo) begin
			res_q <= res_d;
			for (int k = 0; k < TAPS; k++) begin
				lo_q[k] <= LO_PW'($signed(cfg.feedback[k])) *
					LO_PW'($signed({1'b0, y_q[SPLIT_W-1:0]}));
			end
		end
		if (cmd.mul_hi) begin
			for (int k = 0; k < TAPS; k++) begin
				hi_q[k] <= HI_PW'($signed(cfg.feedback[k])) *
					HI_PW'($signed(y_q[STATE_W-1:SPLIT_W]));
			end
		end
		if (cmd.sum) begin
			for (int k = 0; k < TAPS; k++) begin
				fbv_q[k] <= sat_state(SAT_IN_W'(shr_d[k]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			sample_out_q  <= active_q ? res_q : '0;
			out_channel_q <= ch_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign out_channel = out_channel_q;

`ifndef ASSERT_OFF
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result appeared without a commit");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !active_q |=> sample_out_q == '0)
		else $error("unused channel gave a nonzero sample");
	a_idle_no_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !active_q |=> $stable(row_vld_q))
		else $error("unused channel touched delay state");
`endif

endmodule

`default_nettype wire

[rtl/fourth_order_iir_filter_top.sv]
// Fourth-order IIR filter, transposed direct form II, interleaved channels.
// Input channel: in_valid/in_ready carry sample_in (signed Q1.15) and channel.
// Output channel: out_valid/out_ready carry sample_out and out_channel, one
// result per input, in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 channel
// count, 1 highpass, 2 gain, 3..6 feedback one..four); write only when idle.
// Each channel keeps its own four delay values; channels at or above the
// channel count return zero and leave all state alone.
// Steps of the shared datapath per item: accumulate, two partial-product
// passes per feedback tap, recombine, update; the update step writes the
// result into the output register. A new item is taken only once the last
// one has left its update step. The 48-bit accumulator times each 32-bit
// coefficient is split into two halves on four multipliers.
// A finished result waits in the output register; the next item is taken
// meanwhile and holds in its update step if the receiver still stalls.
// Reset clears all delays (row valid bits), config to defaults, no output.
`timescale 1ns / 1ps
`default_nettype none

module fourth_order_iir_filter_top
	import iir4_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CH_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic [CH_W-1:0]            channel,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      sample_out,
	output logic [CH_W-1:0]                 out_channel,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	iir4_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	iir4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	iir4_dp #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status),
		.sample_in   (sample_in),
		.channel     (channel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.out_channel (out_channel)
	);

endmodule

`default_nettype wire
